// ----- src/cau_pkg.sv -----
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, opcodes and helper functions of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int FRAC_BITS_DEF = 16;
  // Number of quotient bits the divider chain produces.
  localparam int QW = 33;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_NEG = 4'd4;
  localparam logic [3:0] OP_EQ  = 4'd5;
  localparam logic [3:0] OP_NE  = 4'd6;
  localparam logic [3:0] OP_LT  = 4'd7;
  localparam logic [3:0] OP_GT  = 4'd8;
  localparam logic [3:0] OP_LE  = 4'd9;
  localparam logic [3:0] OP_GE  = 4'd10;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } sat_t;

  // One division lane: partial remainder, dividend bits still to bring down,
  // quotient bits so far, result sign and an early overflow mark.
  typedef struct packed {
    logic [64:0]   rem;
    logic [QW-1:0] bits;
    logic [QW-1:0] quo;
    logic          neg;
    logic          ovf;
  } lane_t;

  typedef struct packed {
    logic [63:0] den;
    logic        is_div;
    lane_t       re;
    lane_t       im;
    logic [31:0] res_re;
    logic [31:0] res_im;
    logic        cmp;
    logic [1:0]  status;
  } stage_t;

  function automatic sat_t sat32(input logic [64:0] v);
    sat_t r;
    r.sat = 1'b0;
    r.val = v[31:0];
    if (!v[64] && (v[63:31] != '0)) begin
      r.sat = 1'b1;
      r.val = 32'h7FFF_FFFF;
    end else if (v[64] && (v[63:31] != '1)) begin
      r.sat = 1'b1;
      r.val = 32'h8000_0000;
    end
    return r;
  endfunction

  function automatic sat_t div_sat(input lane_t l);
    sat_t r;
    r.sat = 1'b0;
    r.val = l.quo[31:0];
    if (l.ovf) begin
      r.sat = 1'b1;
      r.val = l.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (l.neg) begin
      if (l.quo > 33'h0_8000_0000) begin
        r.sat = 1'b1;
        r.val = 32'h8000_0000;
      end else begin
        r.val = 32'(-l.quo);
      end
    end else if (l.quo[32] || l.quo[31]) begin
      r.sat = 1'b1;
      r.val = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

// ----- src/cau_front.sv -----
// ----------------------------------------------------------------------------
// cau_front
// Two stages: partial products, then sums, saturation and divider lane setup.
// ----------------------------------------------------------------------------
module cau_front
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_vld,
  input  logic [3:0]         action,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  input  logic signed [31:0] b_re,
  input  logic signed [31:0] b_im,
  output logic               out_vld,
  output stage_t             out_stg
);

  logic               vld_a;
  logic [3:0]         act_a;
  logic signed [31:0] ar, ai, br, bi;
  logic signed [63:0] p_rr, p_ii, p_ri, p_ir;
  logic [63:0]        d_r, d_i;
  logic [31:0]        mr, mi;

  assign mr = b_re[31] ? 32'(-b_re) : b_re;
  assign mi = b_im[31] ? 32'(-b_im) : b_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else if (adv) begin
      vld_a <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      act_a <= action;
      ar    <= a_re;
      ai    <= a_im;
      br    <= b_re;
      bi    <= b_im;
      p_rr  <= a_re * b_re;
      p_ii  <= a_im * b_im;
      p_ri  <= a_re * b_im;
      p_ir  <= a_im * b_re;
      d_r   <= mr * mr;
      d_i   <= mi * mi;
    end
  end

  logic [64:0] x_ar, x_ai, x_br, x_bi;
  logic [64:0] m_re, m_im, s_re, s_im;
  logic [63:0] den, n_re, n_im, h_re, h_im;
  sat_t        r0, r1;
  stage_t      nxt;

  assign x_ar = {{33{ar[31]}}, ar};
  assign x_ai = {{33{ai[31]}}, ai};
  assign x_br = {{33{br[31]}}, br};
  assign x_bi = {{33{bi[31]}}, bi};

  // The shift of the exact 65-bit sum is the floor of the scaled product.
  assign m_re = $signed({p_rr[63], p_rr} - {p_ii[63], p_ii}) >>> FRAC_BITS;
  assign m_im = $signed({p_ri[63], p_ri} + {p_ir[63], p_ir}) >>> FRAC_BITS;

  assign s_re = {p_rr[63], p_rr} + {p_ii[63], p_ii};
  assign s_im = {p_ir[63], p_ir} - {p_ri[63], p_ri};
  assign n_re = s_re[64] ? 64'(-s_re) : s_re[63:0];
  assign n_im = s_im[64] ? 64'(-s_im) : s_im[63:0];
  assign den  = d_r + d_i;
  assign h_re = n_re >> (QW - FRAC_BITS);
  assign h_im = n_im >> (QW - FRAC_BITS);

  always_comb begin
    r0 = '0;
    r1 = '0;
    nxt = '0;
    nxt.den       = den;
    nxt.re.rem    = {1'b0, h_re};
    nxt.re.bits   = QW'(n_re << FRAC_BITS);
    nxt.re.neg    = s_re[64];
    nxt.re.ovf    = h_re >= den;
    nxt.im.rem    = {1'b0, h_im};
    nxt.im.bits   = QW'(n_im << FRAC_BITS);
    nxt.im.neg    = s_im[64];
    nxt.im.ovf    = h_im >= den;
    unique case (act_a)
      OP_ADD: begin
        r0 = sat32(x_ar + x_br);
        r1 = sat32(x_ai + x_bi);
      end
      OP_SUB: begin
        r0 = sat32(x_ar - x_br);
        r1 = sat32(x_ai - x_bi);
      end
      OP_MUL: begin
        r0 = sat32(m_re);
        r1 = sat32(m_im);
      end
      OP_DIV: nxt.is_div = 1'b1;
      OP_NEG: begin
        r0 = sat32(65'd0 - x_ar);
        r1 = sat32(65'd0 - x_ai);
      end
      OP_EQ: nxt.cmp = (ar == br) && (ai == bi);
      OP_NE: nxt.cmp = (ar != br) || (ai != bi);
      OP_LT: nxt.cmp = ar < br;
      OP_GT: nxt.cmp = ar > br;
      OP_LE: nxt.cmp = ar <= br;
      OP_GE: nxt.cmp = ar >= br;
      default: ;
    endcase
    nxt.res_re = r0.val;
    nxt.res_im = r1.val;
    nxt.status = (r0.sat || r1.sat) ? ST_SAT : ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= vld_a;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_stg <= nxt;
    end
  end

endmodule

// ----- src/cau_div_cell.sv -----
// ----------------------------------------------------------------------------
// cau_div_cell
// One restoring-division step on both lanes; passes the rest of the word on.
// ----------------------------------------------------------------------------
module cau_div_cell
  import cau_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  logic   in_vld,
  input  stage_t in_stg,
  output logic   out_vld,
  output stage_t out_stg
);

  function automatic lane_t step(input lane_t l, input logic [63:0] d);
    lane_t       r;
    logic [64:0] t;
    logic        ge;
    r  = l;
    t  = {l.rem[63:0], l.bits[QW-1]};
    ge = t >= {1'b0, d};
    r.rem  = ge ? t - {1'b0, d} : t;
    r.quo  = {l.quo[QW-2:0], ge};
    r.bits = {l.bits[QW-2:0], 1'b0};
    return r;
  endfunction

  stage_t nxt;

  always_comb begin
    nxt    = in_stg;
    nxt.re = step(in_stg.re, in_stg.den);
    nxt.im = step(in_stg.im, in_stg.den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_stg <= nxt;
    end
  end

endmodule

// ----- src/complex_arithmetic_unit_top.sv -----
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_top
// Pipelined complex ALU on signed fixed-point operands.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) takes one word per cycle,
// while in_ready is high, with an opcode and two complex operands; the output
// channel (out_valid/out_ready) returns one word per input word, in order,
// with the complex result, the compare bit and a status code (ok, saturated,
// division by zero). Throughput is one word per cycle while the receiver does
// not stall. For every opcode the word passes 36 registers: one product
// stage, one sum stage, a chain of 33 divider cells (one quotient bit each)
// and the output register. The length of that cell chain sets the latency.
// When the receiver stalls with a word held in the output register, the
// whole pipeline holds and in_ready drops; it rises again in the cycle that
// out_ready does. Reset clears every valid bit, so the pipeline comes up
// empty and ready. Nothing is held between words.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_top
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         action,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  input  logic signed [31:0] b_re,
  input  logic signed [31:0] b_im,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] res_re,
  output logic signed [31:0] res_im,
  output logic               cmp_true,
  output logic [1:0]         status
);

  // The pipeline moves as one whenever the output register can take a word.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic   vld [QW+1];
  stage_t stg [QW+1];

  cau_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .in_vld (in_valid),
    .action (action),
    .a_re   (a_re),
    .a_im   (a_im),
    .b_re   (b_re),
    .b_im   (b_im),
    .out_vld(vld[0]),
    .out_stg(stg[0])
  );

  // Each cell decides one quotient bit of both lanes, most significant first.
  for (genvar k = 0; k < QW; k++) begin : g_cell
    cau_div_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .adv    (adv),
      .in_vld (vld[k]),
      .in_stg (stg[k]),
      .out_vld(vld[k+1]),
      .out_stg(stg[k+1])
    );
  end

  // Final selection: divide words take their parts from the lanes, all other
  // opcodes were finished in the front stages and just rode along.
  stage_t      last;
  sat_t        q_re, q_im;
  logic [31:0] f_re, f_im;
  logic [1:0]  f_st;

  assign last = stg[QW];
  assign q_re = div_sat(last.re);
  assign q_im = div_sat(last.im);

  always_comb begin
    f_re = last.res_re;
    f_im = last.res_im;
    f_st = last.status;
    if (last.is_div) begin
      if (last.den == '0) begin
        f_re = '0;
        f_im = '0;
        f_st = ST_DZ;
      end else begin
        f_re = q_re.val;
        f_im = q_im.val;
        f_st = (q_re.sat || q_im.sat) ? ST_SAT : ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_re   <= f_re;
      res_im   <= f_im;
      cmp_true <= last.cmp;
      status   <= f_st;
    end
  end

  // A division by zero never carries a nonzero part.
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_DZ |-> res_re == '0 && res_im == '0)
    else $error("division by zero word carries a nonzero result");

  // A true compare comes with a clean status and zero parts.
  a_cmp_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && cmp_true |-> status == ST_OK && res_re == '0 && res_im == '0)
    else $error("compare word carries arithmetic result");

  // A saturated word has at least one part at a rail.
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_SAT |->
      res_re == 32'h7FFF_FFFF || res_re == 32'h8000_0000 ||
      res_im == 32'h7FFF_FFFF || res_im == 32'h8000_0000)
    else $error("saturation flagged without a clamped part");

  // A stalled output register freezes the pipeline, so no word is accepted.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalls");

endmodule

// ----- verif/tb_complex_arithmetic_unit_top.sv -----
// ----------------------------------------------------------------------------
// tb_complex_arithmetic_unit_top
// Self-checking bench for the pipelined complex ALU.
// ----------------------------------------------------------------------------
// A queue of operand words (directed ones up front, random ones as the run
// goes) is streamed into the block with random idle cycles. Each accepted
// word is run through a local predictor, and its result is queued. The
// monitor pops the oldest result and compares it field by field with what
// comes out of the block. The receiver stalls at random too.
// ----------------------------------------------------------------------------
module tb_complex_arithmetic_unit_top;
  import cau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = FRAC_BITS_DEF;
  localparam int N_RANDOM = 1750;

  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] ar;
    logic signed [31:0] ai;
    logic signed [31:0] br;
    logic signed [31:0] bi;
  } op_word_t;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        cmp;
    logic [1:0]  st;
  } alu_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [3:0]         action = '0;
  logic signed [31:0] a_re = '0;
  logic signed [31:0] a_im = '0;
  logic signed [31:0] b_re = '0;
  logic signed [31:0] b_im = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] res_re;
  logic signed [31:0] res_im;
  logic               cmp_true;
  logic [1:0]         status;

  op_word_t    pending_words[$];
  alu_result_t expected_results[$];
  int          mismatches = 0;
  bit          calm = 1'b0;     // Window in which neither side idles.
  bit          hold_off = 1'b0; // Sender waits for the pipeline to drain.

  always #2 clk = ~clk;

  complex_arithmetic_unit_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
    .out_valid(out_valid), .out_ready(out_ready),
    .res_re(res_re), .res_im(res_im), .cmp_true(cmp_true), .status(status)
  );

  // Clamp a wide signed value to 32 bits and raise the saturation flag.
  function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout bit sat);
    if (v > 128'sh7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -128'sh8000_0000) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Fixed-point quotient truncated toward zero, then saturated.
  function automatic logic [31:0] fx_quot(input logic signed [127:0] num,
                                          input logic signed [127:0] den, inout bit sat);
    logic [127:0] mag;
    logic [127:0] q;
    mag = (num < 0) ? -num : num;
    q = (mag << FB) / den;
    return clamp32((num < 0) ? -$signed(q) : $signed(q), sat);
  endfunction

  function automatic alu_result_t alu_predict(input op_word_t w);
    alu_result_t r;
    bit sat;
    logic signed [127:0] ar, ai, br, bi, den;
    r = '0;
    sat = 1'b0;
    ar = w.ar; ai = w.ai; br = w.br; bi = w.bi;
    case (w.op)
      OP_ADD: begin
        r.re = clamp32(ar + br, sat);
        r.im = clamp32(ai + bi, sat);
      end
      OP_SUB: begin
        r.re = clamp32(ar - br, sat);
        r.im = clamp32(ai - bi, sat);
      end
      OP_MUL: begin
        // Arithmetic shift floors, as the hardware does.
        r.re = clamp32((ar * br - ai * bi) >>> FB, sat);
        r.im = clamp32((ar * bi + ai * br) >>> FB, sat);
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.st = ST_DZ;
        end else begin
          r.re = fx_quot(ar * br + ai * bi, den, sat);
          r.im = fx_quot(ai * br - ar * bi, den, sat);
        end
      end
      OP_NEG: begin
        r.re = clamp32(-ar, sat);
        r.im = clamp32(-ai, sat);
      end
      OP_EQ: r.cmp = (w.ar == w.br) && (w.ai == w.bi);
      OP_NE: r.cmp = (w.ar != w.br) || (w.ai != w.bi);
      OP_LT: r.cmp = w.ar < w.br;
      OP_GT: r.cmp = w.ar > w.br;
      OP_LE: r.cmp = w.ar <= w.br;
      OP_GE: r.cmp = w.ar >= w.br;
      default: ;
    endcase
    if (sat && r.st == ST_OK) r.st = ST_SAT;
    return r;
  endfunction

  // Operand values biased toward the corners of the range.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
      4, 5: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic op_word_t make_word(input logic [3:0] op, input logic [31:0] ar,
                                         input logic [31:0] ai, input logic [31:0] br,
                                         input logic [31:0] bi);
    op_word_t w;
    w.op = op; w.ar = ar; w.ai = ai; w.br = br; w.bi = bi;
    return w;
  endfunction

  // Driver: presents the next word, keeping valid and payload stable until taken.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(alu_predict({action, a_re, a_im, b_re, b_im}));
      end
      if (!in_valid || in_ready) begin
        if (pending_words.size() > 0 && !hold_off && (calm || $urandom_range(0, 99) >= 13))
        begin
          op_word_t w;
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          action <= w.op; a_re <= w.ar; a_im <= w.ai; b_re <= w.br; b_im <= w.bi;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure and result checking.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        alu_result_t want;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result word: re=%h im=%h", res_re, res_im);
        end else begin
          want = expected_results.pop_front();
          if (want !== {res_re, res_im, cmp_true, status}) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected re=%h im=%h cmp=%b st=%0d, got re=%h im=%h cmp=%b st=%0d",
                       want.re, want.im, want.cmp, want.st, res_re, res_im, cmp_true, status);
          end
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 13);
    end
  end

  initial begin
    logic [3:0] op;
    // Directed words: range corners, each opcode, the special cases.
    pending_words.push_back(make_word(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(OP_MUL, 32'h0002_0000, 32'h0001_8000, 32'hFFFF_0000, 32'h3));
    pending_words.push_back(make_word(OP_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                      32'h8000_0000));
    pending_words.push_back(make_word(OP_MUL, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h0));
    pending_words.push_back(make_word(OP_DIV, 32'h0003_0000, 32'h0001_0000, 32'h0, 32'h0));
    pending_words.push_back(make_word(OP_DIV, 32'h0003_0000, 32'hFFFE_0000, 32'h0002_0000, 32'h0));
    pending_words.push_back(make_word(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h0));
    pending_words.push_back(make_word(OP_DIV, 32'h8000_0000, 32'h0, 32'h0001_0000, 32'h0));
    pending_words.push_back(make_word(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      32'h8000_0000));
    pending_words.push_back(make_word(OP_NEG, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5, 32'h9));
    pending_words.push_back(make_word(OP_EQ, 32'h5, 32'h6, 32'h5, 32'h6));
    pending_words.push_back(make_word(OP_EQ, 32'h5, 32'h6, 32'h5, 32'h7));
    pending_words.push_back(make_word(OP_NE, 32'h5, 32'h6, 32'h5, 32'h6));
    pending_words.push_back(make_word(OP_NE, 32'h5, 32'h6, 32'h4, 32'h6));
    pending_words.push_back(make_word(OP_LT, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0));
    pending_words.push_back(make_word(OP_GT, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0));
    pending_words.push_back(make_word(OP_LE, 32'h3, 32'h0, 32'h3, 32'h1));
    pending_words.push_back(make_word(OP_GE, 32'h3, 32'h0, 32'h3, 32'h1));
    pending_words.push_back(make_word(4'd11, 32'h1, 32'h2, 32'h3, 32'h4));
    pending_words.push_back(make_word(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                      32'hFFFF_FFFF));
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (pending_words.size() > 0) @(posedge clk);

    // Let the pipeline drain completely before the random phase.
    hold_off <= 1'b1;
    while (in_valid || expected_results.size() > 0) @(posedge clk);
    hold_off <= 1'b0;

    for (int i = 0; i < N_RANDOM; i++) begin
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15)) : 4'($urandom_range(0, 10));
      if ($urandom_range(0, 3) == 0) begin
        // Equal or nearly equal operands exercise the compares and real scalars.
        logic [31:0] x, y;
        x = pick_operand();
        y = pick_operand();
        pending_words.push_back(make_word(op, x, y, x + 32'($urandom_range(0, 1)),
                                          $urandom_range(0, 1) ? y : 32'h0));
      end else begin
        pending_words.push_back(make_word(op, pick_operand(), pick_operand(), pick_operand(),
                                          pick_operand()));
      end
      // A long stretch in the middle runs with no idling on either side.
      if (i == 600) begin
        while (pending_words.size() > 0) @(posedge clk);
        calm <= 1'b1;
      end
      if (i == 900) begin
        while (pending_words.size() > 0) @(posedge clk);
        calm <= 1'b0;
      end
    end
    while (pending_words.size() > 0 || in_valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_complex_arithmetic_unit_top OK");
    end else begin
      $display("tb_complex_arithmetic_unit_top NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("tb_complex_arithmetic_unit_top NOT OK");
    $finish;
  end

endmodule
